// ----- design/assert_macros.svh -----
// Assertion helpers shared by the tessellator modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define QST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define QST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/qst_pkg.sv -----
`timescale 1ns / 1ps

package qst_pkg;

  // Interpolation parameter f is an unsigned Q0.16 fraction.
  localparam int T_BITS = 16;
  localparam int CNT_BITS = 5;
  localparam logic [CNT_BITS-1:0] MAX_SEG = 5'd21;
  localparam logic [CNT_BITS-1:0] SPN_RESET = 5'd10;
  localparam int LANES = 4;

  typedef logic [T_BITS-1:0] frac_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_SAMPLES = 1'b0,
    REG_CLOSED  = 1'b1
  } cfg_reg_t;

  // Operand sets for the segment registers in each lane.
  typedef enum logic [2:0] {
    SRC_ACCEPT      = 3'd0,
    SRC_WRAP1       = 3'd1,
    SRC_WRAP2       = 3'd2,
    SRC_TAIL_OPEN   = 3'd3,
    SRC_TAIL_CLOSED = 3'd4,
    SRC_ZERO        = 3'd5
  } seg_src_t;

  // One sample offered to the lanes and the merge stage.
  typedef struct packed {
    logic  valid;
    frac_t f;
    logic  last;
    logic  few;
  } issue_t;

  // Control from the sequencer to every lane.
  typedef struct packed {
    logic     adv;
    logic     accept;
    logic     store_wr;
    logic     wr_first0;
    logic     wr_first1;
    logic     seg_ld;
    seg_src_t seg_src;
  } lane_ctl_t;

  // Integer part of 65536 / n. Unused for n = 1 since f never steps there.
  function automatic frac_t step_quot(input cnt_t n);
    frac_t v;
    v = '0;
    case (n)
      5'd2:    v = 16'd32768;
      5'd3:    v = 16'd21845;
      5'd4:    v = 16'd16384;
      5'd5:    v = 16'd13107;
      5'd6:    v = 16'd10922;
      5'd7:    v = 16'd9362;
      5'd8:    v = 16'd8192;
      5'd9:    v = 16'd7281;
      5'd10:   v = 16'd6553;
      5'd11:   v = 16'd5957;
      5'd12:   v = 16'd5461;
      5'd13:   v = 16'd5041;
      5'd14:   v = 16'd4681;
      5'd15:   v = 16'd4369;
      5'd16:   v = 16'd4096;
      5'd17:   v = 16'd3855;
      5'd18:   v = 16'd3640;
      5'd19:   v = 16'd3449;
      5'd20:   v = 16'd3276;
      5'd21:   v = 16'd3120;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Remainder of 65536 / n.
  function automatic cnt_t step_rem(input cnt_t n);
    cnt_t v;
    v = '0;
    case (n)
      5'd3:    v = 5'd1;
      5'd5:    v = 5'd1;
      5'd6:    v = 5'd4;
      5'd7:    v = 5'd2;
      5'd9:    v = 5'd7;
      5'd10:   v = 5'd6;
      5'd11:   v = 5'd9;
      5'd12:   v = 5'd4;
      5'd13:   v = 5'd3;
      5'd14:   v = 5'd2;
      5'd15:   v = 5'd1;
      5'd17:   v = 5'd1;
      5'd18:   v = 5'd16;
      5'd19:   v = 5'd5;
      5'd20:   v = 5'd16;
      5'd21:   v = 5'd16;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/qst_lane.sv -----
`timescale 1ns / 1ps

// One coordinate lane: point history, segment operands and the
// interpolation steps of the quadratic de Casteljau evaluation.
module qst_lane #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  qst_pkg::lane_ctl_t           ctl,
  input  qst_pkg::frac_t               f,
  input  logic signed [COORD_BITS-1:0] in_p,
  output logic signed [COORD_BITS-1:0] q
);

  localparam int TB = qst_pkg::T_BITS;
  localparam int PW = COORD_BITS + TB + 2;

  // Point history; contents are only read after they have been written.
  logic signed [COORD_BITS-1:0] first0_r, first1_r, older_r, newer_r, cur_r;

  // Segment operands: start midpoint, center point, end midpoint.
  logic signed [COORD_BITS-1:0] pa_r, c_r, pb_r;
  logic signed [COORD_BITS-1:0] op_l, op_c, op_r;
  logic signed [COORD_BITS:0]   sum_lc, sum_cr;

  // First interpolation step.
  logic signed [COORD_BITS:0]   d1, d2;
  logic signed [TB:0]           fs, a_fs;
  logic signed [PW-1:0]         prod1, prod2;
  logic signed [COORD_BITS-1:0] a_pa_r, a_c_r;
  logic signed [PW-1:0]         a_prod1_r, a_prod2_r;
  logic [TB-1:0]                a_f_r;

  // Second interpolation step.
  logic signed [COORD_BITS-1:0] p1, p2;
  logic signed [COORD_BITS:0]   d3;
  logic signed [PW-1:0]         prod3;
  logic signed [COORD_BITS-1:0] b_p1_r;
  logic signed [PW-1:0]         b_prod3_r;

  always_comb begin
    op_l = '0;
    op_c = '0;
    op_r = '0;
    case (ctl.seg_src)
      qst_pkg::SRC_ACCEPT: begin
        op_l = older_r;
        op_c = newer_r;
        op_r = in_p;
      end
      qst_pkg::SRC_WRAP1: begin
        op_l = newer_r;
        op_c = cur_r;
        op_r = first0_r;
      end
      qst_pkg::SRC_WRAP2: begin
        op_l = cur_r;
        op_c = first0_r;
        op_r = first1_r;
      end
      qst_pkg::SRC_TAIL_OPEN: begin
        op_l = newer_r;
        op_c = cur_r;
        op_r = cur_r;
      end
      qst_pkg::SRC_TAIL_CLOSED: begin
        op_l = first0_r;
        op_c = first1_r;
        op_r = first1_r;
      end
      default: begin
        op_l = '0;
        op_c = '0;
        op_r = '0;
      end
    endcase
  end

  // Midpoints round toward minus infinity.
  assign sum_lc = {op_l[COORD_BITS-1], op_l} + {op_c[COORD_BITS-1], op_c};
  assign sum_cr = {op_c[COORD_BITS-1], op_c} + {op_r[COORD_BITS-1], op_r};

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cur_r <= in_p;
    end
    if (ctl.store_wr) begin
      older_r <= newer_r;
      newer_r <= in_p;
    end
    if (ctl.wr_first0) begin
      first0_r <= in_p;
    end
    if (ctl.wr_first1) begin
      first1_r <= in_p;
    end
    if (ctl.seg_ld) begin
      pa_r <= sum_lc[COORD_BITS:1];
      c_r  <= op_c;
      pb_r <= sum_cr[COORD_BITS:1];
    end
  end

  assign fs    = {1'b0, f};
  assign d1    = {c_r[COORD_BITS-1], c_r} - {pa_r[COORD_BITS-1], pa_r};
  assign d2    = {pb_r[COORD_BITS-1], pb_r} - {c_r[COORD_BITS-1], c_r};
  assign prod1 = d1 * fs;
  assign prod2 = d2 * fs;

  // The interpolated value always lies between its operands, so the low
  // coordinate bits of the sum are exact.
  assign a_fs  = {1'b0, a_f_r};
  assign p1    = a_pa_r + a_prod1_r[TB +: COORD_BITS];
  assign p2    = a_c_r + a_prod2_r[TB +: COORD_BITS];
  assign d3    = {p2[COORD_BITS-1], p2} - {p1[COORD_BITS-1], p1};
  assign prod3 = d3 * a_fs;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      a_pa_r    <= pa_r;
      a_c_r     <= c_r;
      a_prod1_r <= prod1;
      a_prod2_r <= prod2;
      a_f_r     <= f;
      b_p1_r    <= p1;
      b_prod3_r <= prod3;
    end
  end

  assign q = b_p1_r + b_prod3_r[TB +: COORD_BITS];

endmodule

// ----- design/qst_seq.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sequencer: configuration registers, point count, segment order and the
// sample counter that produces f = floor(j * 65536 / N) incrementally.
module qst_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_final_point,
  output logic                in_ready,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_wdata,
  input  logic                adv,
  output qst_pkg::lane_ctl_t  ctl,
  output qst_pkg::issue_t     issue
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEG  = 3'b010,
    ST_TAIL = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    PH_PREV  = 3'b001,
    PH_WRAP1 = 3'b010,
    PH_WRAP2 = 3'b100
  } phase_t;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [1:0]         seen_r, seen_nxt;
  logic               last_r, last_nxt;
  logic               few_r, few_nxt;
  qst_pkg::cnt_t      j_r, j_nxt;
  qst_pkg::frac_t     f_r, f_nxt;
  qst_pkg::cnt_t      rem_r, rem_nxt;
  qst_pkg::cnt_t      spn_r;
  logic               closed_r;

  logic               accept;
  logic               fire;
  logic               seg_end;
  logic [5:0]         rem_sum;
  logic               seg_ld;
  qst_pkg::seg_src_t  seg_src;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = adv && ((state_r == ST_SEG) || (state_r == ST_TAIL));
  assign seg_end  = fire && (state_r == ST_SEG) && (j_r == spn_r - 5'd1);

  assign issue.valid = (state_r == ST_SEG) || (state_r == ST_TAIL);
  assign issue.f     = (state_r == ST_TAIL) ? '0 : f_r;
  assign issue.last  = (state_r == ST_TAIL);
  assign issue.few   = (state_r == ST_TAIL) && few_r;

  assign ctl.adv       = adv;
  assign ctl.accept    = accept;
  assign ctl.store_wr  = accept && !in_final_point;
  assign ctl.wr_first0 = accept && !in_final_point && (seen_r == 2'd0);
  assign ctl.wr_first1 = accept && !in_final_point && (seen_r == 2'd1);
  assign ctl.seg_ld    = seg_ld;
  assign ctl.seg_src   = seg_src;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    seen_nxt  = seen_r;
    last_nxt  = last_r;
    few_nxt   = few_r;
    seg_ld    = 1'b0;
    seg_src   = qst_pkg::SRC_ACCEPT;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_nxt = in_final_point;
          few_nxt  = 1'b0;
          if (in_final_point) begin
            seen_nxt = 2'd0;
          end else if (seen_r != 2'd3) begin
            seen_nxt = seen_r + 2'd1;
          end
          if (in_final_point && (seen_r < 2'd2)) begin
            seg_ld    = 1'b1;
            seg_src   = qst_pkg::SRC_ZERO;
            few_nxt   = 1'b1;
            state_nxt = ST_TAIL;
          end else if (seen_r >= 2'd2) begin
            seg_ld    = 1'b1;
            seg_src   = qst_pkg::SRC_ACCEPT;
            phase_nxt = PH_PREV;
            state_nxt = ST_SEG;
          end
        end
      end
      ST_SEG: begin
        if (seg_end) begin
          unique case (phase_r)
            PH_PREV: begin
              if (!last_r) begin
                state_nxt = ST_IDLE;
              end else if (closed_r) begin
                seg_ld    = 1'b1;
                seg_src   = qst_pkg::SRC_WRAP1;
                phase_nxt = PH_WRAP1;
              end else begin
                seg_ld    = 1'b1;
                seg_src   = qst_pkg::SRC_TAIL_OPEN;
                state_nxt = ST_TAIL;
              end
            end
            PH_WRAP1: begin
              seg_ld    = 1'b1;
              seg_src   = qst_pkg::SRC_WRAP2;
              phase_nxt = PH_WRAP2;
            end
            default: begin
              seg_ld    = 1'b1;
              seg_src   = qst_pkg::SRC_TAIL_CLOSED;
              state_nxt = ST_TAIL;
            end
          endcase
        end
      end
      ST_TAIL: begin
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // f advances by the quotient of 65536 / N, plus one whenever the
  // accumulated remainder reaches N.
  assign rem_sum = {1'b0, rem_r} + {1'b0, qst_pkg::step_rem(spn_r)};

  always_comb begin
    j_nxt   = j_r;
    f_nxt   = f_r;
    rem_nxt = rem_r;
    if (fire && (state_r == ST_SEG)) begin
      if (seg_end) begin
        j_nxt   = '0;
        f_nxt   = '0;
        rem_nxt = '0;
      end else begin
        j_nxt = j_r + 5'd1;
        if (rem_sum >= {1'b0, spn_r}) begin
          f_nxt   = f_r + qst_pkg::step_quot(spn_r) + 16'd1;
          rem_nxt = 5'(rem_sum - {1'b0, spn_r});
        end else begin
          f_nxt   = f_r + qst_pkg::step_quot(spn_r);
          rem_nxt = rem_sum[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_PREV;
      seen_r   <= '0;
      last_r   <= 1'b0;
      few_r    <= 1'b0;
      j_r      <= '0;
      f_r      <= '0;
      rem_r    <= '0;
      spn_r    <= qst_pkg::SPN_RESET;
      closed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      last_r  <= last_nxt;
      few_r   <= few_nxt;
      j_r     <= j_nxt;
      f_r     <= f_nxt;
      rem_r   <= rem_nxt;
      if (cfg_we) begin
        unique case (qst_pkg::cfg_reg_t'(cfg_index))
          qst_pkg::REG_SAMPLES: begin
            if (cfg_wdata == 5'd0) begin
              spn_r <= 5'd1;
            end else if (cfg_wdata > qst_pkg::MAX_SEG) begin
              spn_r <= qst_pkg::MAX_SEG;
            end else begin
              spn_r <= cfg_wdata;
            end
          end
          qst_pkg::REG_CLOSED: begin
            closed_r <= cfg_wdata[0];
          end
        endcase
      end
    end
  end

  `QST_ASSERT_IMP(a_cnt_in_seg, state_r == ST_SEG, j_r < spn_r, "sample index past segment")
  `QST_ASSERT_IMP(a_spn_range, 1'b1, (spn_r >= 5'd1) && (spn_r <= qst_pkg::MAX_SEG), "bad N")
  `QST_ASSERT_NXT(a_tail_done, (state_r == ST_TAIL) && adv, state_r == ST_IDLE, "tail not done")

endmodule

// ----- design/qst_merge.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Merge stage: tracks which pipeline slots hold samples, joins the four
// lane results with the curve flags and holds the output register.
module qst_merge #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qst_pkg::issue_t              issue,
  input  logic signed [COORD_BITS-1:0] lane_q [qst_pkg::LANES],
  output logic                         adv,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_q [qst_pkg::LANES],
  output logic                         out_end_of_curve,
  output logic                         out_too_few_points
);

  logic                         va_r, a_last_r, a_few_r;
  logic                         vb_r, b_last_r, b_few_r;
  logic                         out_valid_r, out_last_r, out_few_r;
  logic signed [COORD_BITS-1:0] out_q_r [qst_pkg::LANES];

  // The whole pipeline moves together whenever the output slot frees up.
  assign adv = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      va_r        <= issue.valid;
      vb_r        <= va_r;
      out_valid_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_last_r   <= issue.last;
      a_few_r    <= issue.few;
      b_last_r   <= a_last_r;
      b_few_r    <= a_few_r;
      out_last_r <= b_last_r;
      out_few_r  <= b_few_r;
      out_q_r    <= lane_q;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_q              = out_q_r;
  assign out_end_of_curve   = out_last_r;
  assign out_too_few_points = out_few_r;

  `QST_ASSERT_IMP(a_few_zero, out_valid_r && out_few_r, (out_q_r[0] == '0) && (out_q_r[1] == '0) && (out_q_r[2] == '0) && (out_q_r[3] == '0) && out_last_r, "short curve result not zero")

endmodule

// ----- design/quadratic_spline_tessellator_top.sv -----
`timescale 1ns / 1ps

// Quadratic B-spline tessellator. Control points (x, y, z, w in signed
// fixed point, COORD_BITS wide with 16 fraction bits) are transferred in one
// at a time, and the last point of a curve carries in_final_point. Once two
// points are stored, every further point produces the segment centered on
// the point before it: N samples (register samples_per_segment, 1 to 21,
// reset 10) evaluated by quadratic de Casteljau interpolation at
// f = floor(j * 65536 / N). The final point closes the curve with the last
// midpoint, flagged end_of_curve; with closed_loop set, two more segments
// wrap through the first two points before that midpoint. A curve of fewer
// than three points yields a single zero result flagged too_few_points and
// end_of_curve. Each coordinate runs in its own lane, and one sample leaves
// every cycle that the sequencer is issuing and the output is not stalled. An
// ordinary point loads its segment operands as it is transferred in, then
// issues its N samples before the next point is transferred in; a final
// point then adds the two wrap segments if closed_loop is set and then
// the closing midpoint. Results pass from their issue through the two
// multiply stages and the output register, and the input side keeps taking
// points while earlier results wait at the output. Configuration writes
// must only happen while no curve results are outstanding.
module quadratic_spline_tessellator_top #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Control point input.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_px,
  input  logic signed [COORD_BITS-1:0] in_py,
  input  logic signed [COORD_BITS-1:0] in_pz,
  input  logic signed [COORD_BITS-1:0] in_pw,
  input  logic                         in_final_point,
  // Curve sample output.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_qx,
  output logic signed [COORD_BITS-1:0] out_qy,
  output logic signed [COORD_BITS-1:0] out_qz,
  output logic signed [COORD_BITS-1:0] out_qw,
  output logic                         out_end_of_curve,
  output logic                         out_too_few_points,
  // Configuration writes: index 0 is samples_per_segment, 1 is closed_loop.
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [4:0]                   cfg_wdata
);

  qst_pkg::lane_ctl_t           ctl;
  qst_pkg::issue_t              issue;
  logic                         adv;
  logic signed [COORD_BITS-1:0] in_p   [qst_pkg::LANES];
  logic signed [COORD_BITS-1:0] lane_q [qst_pkg::LANES];
  logic signed [COORD_BITS-1:0] out_q  [qst_pkg::LANES];

  assign in_p[0] = in_px;
  assign in_p[1] = in_py;
  assign in_p[2] = in_pz;
  assign in_p[3] = in_pw;

  // The sequencer decides which operands each segment uses and issues one
  // sample per cycle while it has samples to issue and the output side keeps moving.
  qst_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_final_point (in_final_point),
    .in_ready       (in_ready),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .adv            (adv),
    .ctl            (ctl),
    .issue          (issue)
  );

  // One lane per homogeneous coordinate, all driven by the same control.
  for (genvar g = 0; g < qst_pkg::LANES; g++) begin : g_lane
    qst_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .f    (issue.f),
      .in_p (in_p[g]),
      .q    (lane_q[g])
    );
  end

  // The merge stage joins the lane results with the curve flags and owns
  // the output register, which also sets the pipeline advance.
  qst_merge #(
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .clk                (clk),
    .rst_n              (rst_n),
    .issue              (issue),
    .lane_q             (lane_q),
    .adv                (adv),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_q              (out_q),
    .out_end_of_curve   (out_end_of_curve),
    .out_too_few_points (out_too_few_points)
  );

  assign out_qx = out_q[0];
  assign out_qy = out_q[1];
  assign out_qz = out_q[2];
  assign out_qw = out_q[3];

endmodule
